// ===== rtl/midi_channel_state_tracker_unit_defines.svh =====
// Assertion macros shared by the checker of the MIDI channel state tracker.
`ifndef MIDI_CHANNEL_STATE_TRACKER_UNIT_DEFINES_SVH
`define MIDI_CHANNEL_STATE_TRACKER_UNIT_DEFINES_SVH

// check on every clock edge out of reset
`define MCST_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check on every clock edge, reset included
`define MCST_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/mcst_pkg.sv =====
// Types and constants of the MIDI channel state tracker.
`timescale 1ns / 1ps
`default_nettype none
package mcst_pkg;

   localparam int KIND_W          = 4;
   localparam int NUMBER_W        = 7;
   localparam int VALUE_W         = 7;
   localparam int BEND_W          = 14;
   localparam int SLOT_W          = 14;
   localparam int CHANNEL_W       = 4;
   localparam int NOTES_W         = 16;
   localparam int NUM_CONTROLLERS = 128;
   localparam int COUNT_WIDTH     = 16;
   localparam int CTRL_DEPTH      = 128;
   localparam int POLY_DEPTH      = 128;
   localparam int WIDE_DEPTH      = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CTRL_AW         = $clog2(CTRL_DEPTH);
   localparam int POLY_AW         = $clog2(POLY_DEPTH);
   localparam int WIDE_AW         = $clog2(WIDE_DEPTH);

   localparam logic [KIND_W-1:0] KIND_NOTE_OFF   = 4'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_ON    = 4'd1;
   localparam logic [KIND_W-1:0] KIND_POLY       = 4'd2;
   localparam logic [KIND_W-1:0] KIND_CONTROLLER = 4'd3;
   localparam logic [KIND_W-1:0] KIND_PROGRAM    = 4'd4;
   localparam logic [KIND_W-1:0] KIND_PRESSURE   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_BEND       = 4'd6;
   localparam logic [KIND_W-1:0] KIND_RESET      = 4'd7;
   localparam logic [KIND_W-1:0] KIND_READ_CTRL  = 4'd8;
   localparam logic [KIND_W-1:0] KIND_READ_POLY  = 4'd9;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [NUMBER_W-1:0] number;
      logic [VALUE_W-1:0]  value;
      logic [BEND_W-1:0]   bend;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]    slot_value;
      logic                 bank_changed;
      logic [SLOT_W-1:0]    bank;
      logic [VALUE_W-1:0]   program_res;
      logic [BEND_W-1:0]    pitch;
      logic [VALUE_W-1:0]   chan_pressure;
      logic [NOTES_W-1:0]   notes_held;
      logic [NUMBER_W-1:0]  last_on_note;
      logic [VALUE_W-1:0]   last_on_velocity;
      logic [NUMBER_W-1:0]  last_off_note;
      logic [VALUE_W-1:0]   last_off_velocity;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_NOTE_OFF,
      OP_NOTE_ON,
      OP_POLY_WR,
      OP_CTRL_MSB,
      OP_CTRL_LSB,
      OP_CTRL_PLAIN,
      OP_PROGRAM,
      OP_PRESSURE,
      OP_BEND,
      OP_CLEAR,
      OP_READ_CTRL,
      OP_READ_POLY
   } op_code_type;

   typedef struct packed {
      op_code_type         code;
      logic [CTRL_AW-1:0]  slot;
      logic [VALUE_W-1:0]  value;
      logic [BEND_W-1:0]   bend;
      logic                bank_wr;
   } op_type;

endpackage
`default_nettype wire

// ===== rtl/mcst_front.sv =====
// Front end: accepts requests and classifies them into table operations.
`timescale 1ns / 1ps
`default_nettype none
module mcst_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  mcst_pkg::req_type req_payload,
   output logic             push_valid,
   input  logic             push_ready,
   output mcst_pkg::op_type push_data
);
   import mcst_pkg::*;

   localparam logic [NUMBER_W:0]   CTRL_LIMIT = (NUMBER_W + 1)'(NUM_CONTROLLERS);
   localparam logic [NUMBER_W-1:0] MSB_LAST   = 7'd31;
   localparam logic [NUMBER_W-1:0] LSB_LAST   = 7'd63;
   localparam logic [NUMBER_W-1:0] LSB_OFFSET = 7'd32;

   logic in_range;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign in_range   = {1'b0, req_payload.number} < CTRL_LIMIT;

   always_comb begin
      push_data.code    = OP_NOP;
      push_data.slot    = CTRL_AW'(req_payload.number);
      push_data.value   = req_payload.value;
      push_data.bend    = req_payload.bend;
      push_data.bank_wr = 1'b0;
      unique case (req_payload.kind)
         KIND_NOTE_OFF:  push_data.code = OP_NOTE_OFF;
         KIND_NOTE_ON:   push_data.code = OP_NOTE_ON;
         KIND_POLY:      push_data.code = OP_POLY_WR;
         KIND_CONTROLLER: begin
            if (!in_range) begin
               push_data.code = OP_NOP;
            end else if (req_payload.number <= MSB_LAST) begin
               push_data.code    = OP_CTRL_MSB;
               push_data.bank_wr = (req_payload.number == '0);
            end else if (req_payload.number <= LSB_LAST) begin
               push_data.code = OP_CTRL_LSB;
               push_data.slot = CTRL_AW'(req_payload.number - LSB_OFFSET);
            end else begin
               push_data.code = OP_CTRL_PLAIN;
            end
         end
         KIND_PROGRAM:   push_data.code = OP_PROGRAM;
         KIND_PRESSURE:  push_data.code = OP_PRESSURE;
         KIND_BEND:      push_data.code = OP_BEND;
         KIND_RESET:     push_data.code = OP_CLEAR;
         KIND_READ_CTRL: push_data.code = in_range ? OP_READ_CTRL : OP_NOP;
         KIND_READ_POLY: push_data.code = OP_READ_POLY;
         default:        push_data.code = OP_NOP;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/mcst_queue.sv =====
// Short queue of classified operations between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module mcst_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  mcst_pkg::op_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output mcst_pkg::op_type pop_data
);
   import mcst_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   op_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mcst_back.sv =====
// Back end: read-modify-write sequencer over the channel tables and registers.
`timescale 1ns / 1ps
`default_nettype none
module mcst_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mcst_pkg::CHANNEL_W-1:0]   csr_data,
   input  logic                             op_valid,
   output logic                             op_ready,
   input  mcst_pkg::op_type                 op_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mcst_pkg::rsp_type                rsp_payload
);
   import mcst_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;

   logic [SLOT_W-1:0]      ctrl_mem [CTRL_DEPTH];
   logic [VALUE_W-1:0]     poly_mem [POLY_DEPTH];
   logic [SLOT_W-1:0]      ctrl_rd_ff;
   logic [VALUE_W-1:0]     poly_rd_ff;
   logic                   ctrl_hit_ff, ctrl_hit_in;
   logic                   poly_hit_ff, poly_hit_in;
   logic [CTRL_DEPTH-1:0]  ctrl_vld_ff, ctrl_vld_in;
   logic [POLY_DEPTH-1:0]  poly_vld_ff, poly_vld_in;
   logic [WIDE_DEPTH-1:0]  wide_ff, wide_in;

   logic [CHANNEL_W-1:0]   channel_ff, channel_in;
   logic [VALUE_W-1:0]     program_ff, program_in;
   logic [SLOT_W-1:0]      bank_ff, bank_in;
   logic [BEND_W-1:0]      bend_ff, bend_in;
   logic [VALUE_W-1:0]     pressure_ff, pressure_in;
   logic [COUNT_WIDTH-1:0] held_ff, held_in;
   logic [NUMBER_W-1:0]    on_note_ff, on_note_in;
   logic [VALUE_W-1:0]     on_vel_ff, on_vel_in;
   logic [NUMBER_W-1:0]    off_note_ff, off_note_in;
   logic [VALUE_W-1:0]     off_vel_ff, off_vel_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   pop, fire;
   logic                   ctrl_we, poly_we;
   logic [SLOT_W-1:0]      ctrl_wdata;
   logic [SLOT_W-1:0]      cur_ctrl;
   logic [VALUE_W-1:0]     cur_poly;
   logic                   wide_cur;
   logic [SLOT_W-1:0]      slot_value;
   logic                   bank_chg;

   assign csr_ready   = 1'b1;
   assign op_ready    = (state_ff == S_IDLE);
   assign pop         = op_valid && op_ready;
   assign fire        = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign cur_ctrl = ctrl_hit_ff ? ctrl_rd_ff : '0;
   assign cur_poly = poly_hit_ff ? poly_rd_ff : '0;
   assign wide_cur = wide_ff[op_ff.slot[WIDE_AW-1:0]];

   always_comb begin
      state_in    = state_ff;
      op_in       = pop ? op_data : op_ff;
      ctrl_hit_in = pop ? ctrl_vld_ff[op_data.slot] : ctrl_hit_ff;
      poly_hit_in = pop ? poly_vld_ff[op_data.slot] : poly_hit_ff;
      ctrl_vld_in = ctrl_vld_ff;
      poly_vld_in = poly_vld_ff;
      wide_in     = wide_ff;
      channel_in  = csr_valid ? csr_data : channel_ff;
      program_in  = program_ff;
      bank_in     = bank_ff;
      bend_in     = bend_ff;
      pressure_in = pressure_ff;
      held_in     = held_ff;
      on_note_in  = on_note_ff;
      on_vel_in   = on_vel_ff;
      off_note_in = off_note_ff;
      off_vel_in  = off_vel_ff;
      ctrl_we     = 1'b0;
      poly_we     = 1'b0;
      ctrl_wdata  = '0;
      slot_value  = '0;
      bank_chg    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (fire) begin
         case (op_ff.code)
            OP_NOTE_OFF: begin
               off_note_in = NUMBER_W'(op_ff.slot);
               off_vel_in  = op_ff.value;
               if (held_ff != '0) begin
                  held_in = held_ff - 1'b1;
               end
            end
            OP_NOTE_ON: begin
               on_note_in = NUMBER_W'(op_ff.slot);
               on_vel_in  = op_ff.value;
               if (held_ff != COUNT_MAX) begin
                  held_in = held_ff + 1'b1;
               end
            end
            OP_POLY_WR: begin
               poly_we                  = 1'b1;
               poly_vld_in[op_ff.slot]  = 1'b1;
               slot_value               = SLOT_W'(op_ff.value);
            end
            OP_CTRL_MSB: begin
               ctrl_we    = 1'b1;
               ctrl_wdata = wide_cur ? {op_ff.value, cur_ctrl[VALUE_W-1:0]}
                                     : SLOT_W'(op_ff.value);
            end
            OP_CTRL_LSB: begin
               ctrl_we                            = 1'b1;
               wide_in[op_ff.slot[WIDE_AW-1:0]]   = 1'b1;
               ctrl_wdata = wide_cur ? {cur_ctrl[SLOT_W-1:VALUE_W], op_ff.value}
                                     : {cur_ctrl[VALUE_W-1:0], op_ff.value};
            end
            OP_CTRL_PLAIN: begin
               ctrl_we    = 1'b1;
               ctrl_wdata = SLOT_W'(op_ff.value);
            end
            OP_PROGRAM:   program_in  = op_ff.value;
            OP_PRESSURE:  pressure_in = op_ff.value;
            OP_BEND:      bend_in     = op_ff.bend;
            OP_CLEAR: begin
               ctrl_vld_in = '0;
               poly_vld_in = '0;
               wide_in     = '0;
               program_in  = VALUE_W'(channel_ff);
               bank_in     = '0;
               bend_in     = '0;
               held_in     = '0;
               on_note_in  = '0;
               on_vel_in   = '0;
               off_note_in = '0;
               off_vel_in  = '0;
            end
            OP_READ_CTRL: slot_value = cur_ctrl;
            OP_READ_POLY: slot_value = SLOT_W'(cur_poly);
            default: ;
         endcase
         if (ctrl_we) begin
            ctrl_vld_in[op_ff.slot] = 1'b1;
            slot_value              = ctrl_wdata;
            if (op_ff.bank_wr) begin
               bank_in  = ctrl_wdata;
               bank_chg = 1'b1;
            end
         end
      end

      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      rsp_in       = rsp_ff;
      if (fire) begin
         rsp_in.slot_value        = slot_value;
         rsp_in.bank_changed      = bank_chg;
         rsp_in.bank              = bank_in;
         rsp_in.program_res       = program_in;
         rsp_in.pitch             = bend_in;
         rsp_in.chan_pressure     = pressure_in;
         rsp_in.notes_held        = NOTES_W'(held_in);
         rsp_in.last_on_note      = on_note_in;
         rsp_in.last_on_velocity  = on_vel_in;
         rsp_in.last_off_note     = off_note_in;
         rsp_in.last_off_velocity = off_vel_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ctrl_hit_ff <= ctrl_hit_in;
      poly_hit_ff <= poly_hit_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         ctrl_vld_ff  <= '0;
         poly_vld_ff  <= '0;
         wide_ff      <= '0;
         channel_ff   <= '0;
         program_ff   <= '0;
         bank_ff      <= '0;
         bend_ff      <= '0;
         pressure_ff  <= '0;
         held_ff      <= '0;
         on_note_ff   <= '0;
         on_vel_ff    <= '0;
         off_note_ff  <= '0;
         off_vel_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctrl_vld_ff  <= ctrl_vld_in;
         poly_vld_ff  <= poly_vld_in;
         wide_ff      <= wide_in;
         channel_ff   <= channel_in;
         program_ff   <= program_in;
         bank_ff      <= bank_in;
         bend_ff      <= bend_in;
         pressure_ff  <= pressure_in;
         held_ff      <= held_in;
         on_note_ff   <= on_note_in;
         on_vel_ff    <= on_vel_in;
         off_note_ff  <= off_note_in;
         off_vel_ff   <= off_vel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ctrl_rd_ff <= ctrl_mem[op_data.slot];
         poly_rd_ff <= poly_mem[op_data.slot];
      end
      if (ctrl_we) begin
         ctrl_mem[op_ff.slot] <= ctrl_wdata;
      end
      if (poly_we) begin
         poly_mem[op_ff.slot] <= op_ff.value;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/midi_channel_state_tracker_unit.sv =====
// Top level of the MIDI channel state tracker.
//
//   channel   direction  payload                   purpose
//   req_      in         mcst_pkg::req_type        parsed channel message
//   rsp_      out        mcst_pkg::rsp_type        addressed entry and channel snapshot
//   csr_      in         channel number, 4 bits    channel id register write
//
// The back end finishes each request before taking the next: it reads the single-port
// controller and poly tables when it takes a request and writes them back when done.
// A response passes the queue entry, the back end's operation registers and rsp_ff.
// Reset is synchronous; tables clear at once through per-entry valid flops.
// A stalled response holds the back end; the queue takes two more requests.
`timescale 1ns / 1ps
`default_nettype none
module midi_channel_state_tracker_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mcst_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mcst_pkg::rsp_type               rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mcst_pkg::CHANNEL_W-1:0]  csr_data
);
   import mcst_pkg::*;

   logic   push_valid, push_ready;
   op_type push_data;
   logic   op_valid, op_ready;
   op_type op_data;

   mcst_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   mcst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (op_valid),
      .pop_ready  (op_ready),
      .pop_data   (op_data)
   );

   mcst_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .op_valid    (op_valid),
      .op_ready    (op_ready),
      .op_data     (op_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== rtl/mcst_checker.sv =====
// Port-level checks of the MIDI channel state tracker and their binding.
`timescale 1ns / 1ps
`default_nettype none
`include "midi_channel_state_tracker_unit_defines.svh"
module mcst_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mcst_pkg::rsp_type rsp_payload
);

   `MCST_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `MCST_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "stalled response changed")
   `MCST_ASSERT(a_bank_slot, rsp_valid && rsp_payload.bank_changed |-> rsp_payload.slot_value == rsp_payload.bank, "bank differs from controller 0")
   `MCST_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "response right after reset")

endmodule

bind midi_channel_state_tracker_unit mcst_checker u_checker (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
// MIDI channel state tracker testbench: responses checked against fixed or predicted values.
`timescale 1ns / 1ps
module tb_top;
   import mcst_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int PHASE_ITEMS = 542;
   localparam int LAST_MSB_CTRL = 31;
   localparam int LAST_LSB_CTRL = 63;
   localparam int LSB_OFFSET = 32;
   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 4'd10;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST = 4'd15;

   typedef struct {
      req_type msg;
      bit      fixed;
      rsp_type want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CHANNEL_W-1:0] csr_data = '0;

   // channel model
   logic [CHANNEL_W-1:0]   channel_sel;
   logic [SLOT_W-1:0]      ctrl_state [CTRL_DEPTH];
   bit                     wide_state [WIDE_DEPTH];
   logic [VALUE_W-1:0]     poly_state [POLY_DEPTH];
   logic [VALUE_W-1:0]     program_state;
   logic [SLOT_W-1:0]      bank_state;
   logic [BEND_W-1:0]      bend_state;
   logic [VALUE_W-1:0]     pressure_state;
   logic [COUNT_WIDTH-1:0] held_notes;
   logic [NUMBER_W-1:0]    on_note, off_note;
   logic [VALUE_W-1:0]     on_velocity, off_velocity;

   rsp_type      expected_snapshots [$];
   rsp_type      oldest_snapshot;
   stim_row_type directed_rows [$];
   int           sent_count = 0;
   int           checked_count = 0;
   int           mismatch_count = 0;
   int           settings_count = 0;
   int           cycle_count = 0;
   int           burst_left = 1;
   int           stall_beat = 0;
   int           stall_len = 0;
   bit           quiet = 1'b0;

   midi_channel_state_tracker_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   function automatic void clear_channel_state();
      for (int i = 0; i < CTRL_DEPTH; i++) ctrl_state[i] = '0;
      for (int i = 0; i < WIDE_DEPTH; i++) wide_state[i] = 1'b0;
      for (int i = 0; i < POLY_DEPTH; i++) poly_state[i] = '0;
      program_state = {3'b000, channel_sel};
      bank_state = '0;
      bend_state = '0;
      held_notes = '0;
      on_note = '0;
      on_velocity = '0;
      off_note = '0;
      off_velocity = '0;
   endfunction

   function automatic rsp_type apply_message(input req_type msg);
      rsp_type           snap;
      logic [SLOT_W-1:0] cv;
      int                slot;
      snap = '0;
      case (msg.kind)
         KIND_NOTE_OFF: begin
            off_note = msg.number;
            off_velocity = msg.value;
            if (held_notes != '0) held_notes--;
         end
         KIND_NOTE_ON: begin
            on_note = msg.number;
            on_velocity = msg.value;
            if (held_notes != {COUNT_WIDTH{1'b1}}) held_notes++;
         end
         KIND_POLY: begin
            poly_state[msg.number] = msg.value;
            snap.slot_value = {7'd0, msg.value};
         end
         KIND_CONTROLLER: begin
            if (msg.number < NUM_CONTROLLERS) begin
               if (msg.number <= LAST_MSB_CTRL) begin
                  slot = msg.number;
                  if (wide_state[slot]) cv = {msg.value, ctrl_state[slot][6:0]};
                  else cv = {7'd0, msg.value};
               end else if (msg.number <= LAST_LSB_CTRL) begin
                  slot = msg.number - LSB_OFFSET;
                  if (!wide_state[slot]) begin
                     wide_state[slot] = 1'b1;
                     cv = {ctrl_state[slot][6:0], msg.value};
                  end else begin
                     cv = {ctrl_state[slot][13:7], msg.value};
                  end
               end else begin
                  slot = msg.number;
                  cv = {7'd0, msg.value};
               end
               ctrl_state[slot] = cv;
               snap.slot_value = cv;
               if (msg.number == 0) begin
                  bank_state = cv;
                  snap.bank_changed = 1'b1;
               end
            end
         end
         KIND_PROGRAM: program_state = msg.value;
         KIND_PRESSURE: pressure_state = msg.value;
         KIND_BEND: bend_state = msg.bend;
         KIND_RESET: clear_channel_state();
         KIND_READ_CTRL: begin
            if (msg.number < NUM_CONTROLLERS) snap.slot_value = ctrl_state[msg.number];
         end
         KIND_READ_POLY: snap.slot_value = {7'd0, poly_state[msg.number]};
         default: ;
      endcase
      snap.bank = bank_state;
      snap.program_res = program_state;
      snap.pitch = bend_state;
      snap.chan_pressure = pressure_state;
      snap.notes_held = held_notes[NOTES_W-1:0];
      snap.last_on_note = on_note;
      snap.last_on_velocity = on_velocity;
      snap.last_off_note = off_note;
      snap.last_off_velocity = off_velocity;
      return snap;
   endfunction

   function automatic req_type mk_req(input logic [KIND_W-1:0] kind, input int number,
                                      input int value, input int bend);
      req_type msg;
      msg.kind = kind;
      msg.number = number[NUMBER_W-1:0];
      msg.value = value[VALUE_W-1:0];
      msg.bend = bend[BEND_W-1:0];
      return msg;
   endfunction

   function automatic int pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 0;
      if (sel == 1) return 127;
      return $urandom_range(0, 127);
   endfunction

   function automatic req_type random_message();
      req_type msg;
      int      sel;
      sel = $urandom_range(0, 99);
      msg = mk_req(KIND_NOTE_ON, $urandom_range(0, 127), pick_value(), $urandom_range(0, 16383));
      if (sel < 30) begin
         msg.kind = KIND_CONTROLLER;
         if ($urandom_range(0, 9) < 7) msg.number = NUMBER_W'($urandom_range(0, LAST_LSB_CTRL));
      end else if (sel < 45) msg.kind = KIND_NOTE_ON;
      else if (sel < 58) msg.kind = KIND_NOTE_OFF;
      else if (sel < 66) msg.kind = KIND_POLY;
      else if (sel < 74) begin
         msg.kind = KIND_READ_CTRL;
         if ($urandom_range(0, 9) < 7) msg.number = NUMBER_W'($urandom_range(0, LAST_LSB_CTRL));
      end else if (sel < 80) msg.kind = KIND_READ_POLY;
      else if (sel < 85) msg.kind = KIND_PROGRAM;
      else if (sel < 90) msg.kind = KIND_PRESSURE;
      else if (sel < 95) begin
         msg.kind = KIND_BEND;
         if ($urandom_range(0, 5) == 0) msg.bend = $urandom_range(0, 1) ? 14'h3fff : 14'h0000;
      end else if (sel < 97) msg.kind = KIND_RESET;
      else msg.kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      return msg;
   endfunction

   task automatic add_row(input req_type msg, input bit fixed = 1'b0, input rsp_type want = '0);
      stim_row_type row;
      row.msg = msg;
      row.fixed = fixed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   task automatic send_request(input req_type msg, input bit fixed, input rsp_type want);
      rsp_type predicted;
      int      gap;
      req_valid <= 1'b1;
      req_payload <= msg;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_message(msg);
      expected_snapshots.push_back(fixed ? want : predicted);
      sent_count++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 16);
      end
   endtask

   task automatic write_channel(input logic [CHANNEL_W-1:0] id);
      req_valid <= 1'b0;
      while (expected_snapshots.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= id;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      channel_sel = id;
      settings_count++;
   endtask

   task automatic random_phase(input int count);
      repeat (count) send_request(random_message(), 1'b0, '0);
   endtask

   task automatic check_snapshot(input rsp_type want, input rsp_type got);
      string bad;
      bad = "";
      if (got.slot_value !== want.slot_value) bad = {bad, " slot_value"};
      if (got.bank_changed !== want.bank_changed) bad = {bad, " bank_changed"};
      if (got.bank !== want.bank) bad = {bad, " bank"};
      if (got.program_res !== want.program_res) bad = {bad, " program_res"};
      if (got.pitch !== want.pitch) bad = {bad, " pitch"};
      if (got.chan_pressure !== want.chan_pressure) bad = {bad, " chan_pressure"};
      if (got.notes_held !== want.notes_held) bad = {bad, " notes_held"};
      if (got.last_on_note !== want.last_on_note) bad = {bad, " last_on_note"};
      if (got.last_on_velocity !== want.last_on_velocity) bad = {bad, " last_on_velocity"};
      if (got.last_off_note !== want.last_off_note) bad = {bad, " last_off_note"};
      if (got.last_off_velocity !== want.last_off_velocity) bad = {bad, " last_off_velocity"};
      checked_count++;
      if (bad != "") begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("response %0d differs in%s: expected %p, got %p",
                     checked_count, bad, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_snapshots.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response with no request outstanding: %p", rsp_payload);
         end else begin
            oldest_snapshot = expected_snapshots.pop_front();
            check_snapshot(oldest_snapshot, rsp_payload);
         end
      end
   end

   // stall pattern with long stall-free stretches
   always @(posedge clock) begin
      stall_beat = (stall_beat + 1) % 13;
      if (stall_beat == 0) begin
         stall_len = $urandom_range(0, 6);
         if ($urandom_range(0, 19) == 0) quiet = !quiet;
      end
      rsp_ready <= quiet || (stall_beat >= stall_len);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_snapshots.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      channel_sel = '0;
      clear_channel_state();
      pressure_state = '0;

      add_row(mk_req(KIND_READ_CTRL, 0, 0, 0), 1'b1, '0);
      add_row(mk_req(KIND_NOTE_OFF, 127, 127, 16383), 1'b1,
              '{last_off_note: 7'd127, last_off_velocity: 7'd127, default: '0});
      add_row(mk_req(KIND_NOTE_ON, 0, 0, 0), 1'b1,
              '{notes_held: 16'd1, last_off_note: 7'd127, last_off_velocity: 7'd127,
                default: '0});
      add_row(mk_req(KIND_NOTE_ON, 127, 127, 16383));
      add_row(mk_req(KIND_POLY, 127, 127, 0));
      add_row(mk_req(KIND_POLY, 0, 0, 16383));
      add_row(mk_req(KIND_READ_POLY, 127, 0, 0));
      add_row(mk_req(KIND_CONTROLLER, 0, 127, 0));
      add_row(mk_req(KIND_CONTROLLER, 32, 127, 0));
      add_row(mk_req(KIND_CONTROLLER, 0, 1, 0));
      add_row(mk_req(KIND_CONTROLLER, 63, 5, 0));
      add_row(mk_req(KIND_CONTROLLER, 31, 127, 0));
      add_row(mk_req(KIND_CONTROLLER, 64, 127, 0));
      add_row(mk_req(KIND_CONTROLLER, 127, 0, 0));
      add_row(mk_req(KIND_READ_CTRL, 31, 0, 0));
      add_row(mk_req(KIND_READ_CTRL, 32, 0, 0));
      add_row(mk_req(KIND_READ_CTRL, 64, 0, 0));
      add_row(mk_req(KIND_PROGRAM, 0, 127, 0));
      add_row(mk_req(KIND_PRESSURE, 0, 127, 0));
      add_row(mk_req(KIND_BEND, 0, 0, 16383));
      add_row(mk_req(KIND_RESET, 127, 127, 16383));
      add_row(mk_req(KIND_READ_CTRL, 0, 0, 0));
      add_row(mk_req(KIND_NOTE_OFF, 5, 9, 0));
      add_row(mk_req(KIND_SPARE_LAST, 127, 127, 16383));
      add_row(mk_req(KIND_SPARE_FIRST, 0, 0, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].msg, directed_rows[i].fixed, directed_rows[i].want);

      write_channel(4'd15);
      random_phase(PHASE_ITEMS);
      write_channel(4'd0);
      random_phase(PHASE_ITEMS);
      write_channel(CHANNEL_W'($urandom_range(1, 14)));
      random_phase(PHASE_ITEMS);
      req_valid <= 1'b0;

      while (expected_snapshots.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d channel messages under %0d channel numbers, %0d responses checked.",
               sent_count, settings_count + 1, checked_count);
      $display("Bursty traffic over notes, controllers, poly, reset and reads; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mcst_pkg.sv
rtl/mcst_front.sv
rtl/mcst_queue.sv
rtl/mcst_back.sv
rtl/midi_channel_state_tracker_unit.sv
rtl/mcst_checker.sv
sim/tb_top.sv
